[rtl/square_wave_sound_channel_macros.svh]
// Assertion macros for the pulse sound channel checker.
// Used by sqw_checker; no other dependencies.
`ifndef SQUARE_WAVE_SOUND_CHANNEL_MACROS_SVH
`define SQUARE_WAVE_SOUND_CHANNEL_MACROS_SVH

// same-cycle implication
`define SQW_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sqw assertion failed");

// next-cycle implication
`define SQW_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sqw assertion failed");

`endif

[rtl/sqw_pkg.sv]
// Shared types, codes and tables of the pulse sound channel.
// No dependencies; used by the top level, front end, queue and back end.
package sqw_pkg;

  localparam int QueueDepth = 2;

  localparam logic [11:0] PeriodLimit = 12'hFFF;
  localparam logic [11:0] PeriodMin   = 12'd7;
  localparam logic [3:0]  LevelMax    = 4'hF;

  typedef enum logic [2:0] {
    OP_REG_WRITE  = 3'd0,
    OP_ENABLE     = 3'd1,
    OP_LEN_CLOCK  = 3'd2,
    OP_ENV_CLOCK  = 3'd3,
    OP_SWP_CLOCK  = 3'd4,
    OP_DUTY_STEP  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    REG_ENVELOPE = 2'd0,
    REG_SWEEP    = 2'd1,
    REG_PER_LO   = 2'd2,
    REG_PER_HI   = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_WR_ENV,
    CMD_WR_SWEEP,
    CMD_WR_PER_LO,
    CMD_WR_PER_HI,
    CMD_ENABLE,
    CMD_LEN_CLK,
    CMD_ENV_CLK,
    CMD_SWP_CLK,
    CMD_DUTY_STEP
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  length_count;
    logic [2:0]  duty_position;
    logic [4:0]  env_divider;
    logic [3:0]  env_level;
    logic [3:0]  out_volume;
    logic [11:0] timer_period;
    logic [3:0]  sweep_divider;
    logic [2:0]  sweep_rate;
    logic [2:0]  sweep_shift;
    logic        sweep_down;
    logic        sweep_on;
    logic        sweep_reload;
    logic        carry_flag;
    logic [3:0]  env_rate;
    logic        const_volume;
    logic        env_loop;
    logic        length_enable;
    logic [1:0]  duty_select;
    logic        channel_on;
    logic        env_restart;
    logic [3:0]  held_sample;
  } chan_t;

  typedef struct packed {
    logic [3:0] sample;
    logic       length_active;
    logic       sweep_overflow;
  } result_t;

  localparam logic [7:0] LengthTable [32] = '{
    8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
    8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
    8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
    8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
  };

  // bit n of a row is the duty output at position n
  localparam logic [7:0] DutyTable [4] = '{
    8'b0000_0010, 8'b0000_0110, 8'b0001_1110, 8'b1111_1001
  };

  function automatic logic [3:0] resample(
    logic        on,
    logic [7:0]  len,
    logic [11:0] period,
    logic        down,
    logic [2:0]  shift,
    logic [3:0]  vol,
    logic [1:0]  duty_sel,
    logic [2:0]  duty_pos
  );
    logic [12:0] sum;
    logic [7:0]  row;
    logic [3:0]  res;
    sum = {1'b0, period} + {1'b0, period >> shift};
    row = DutyTable[duty_sel];
    res = '0;
    if (on && len != '0 && period > PeriodMin) begin
      if (!down && sum > {1'b0, PeriodLimit}) begin
        res = '0;
      end else begin
        res = row[duty_pos] ? vol : '0;
      end
    end
    return res;
  endfunction

endpackage

[rtl/sqw_if.sv]
// Handshake channels of the pulse sound channel: event in, result out, config.
// Stand-alone; payload widths are fixed by the channel fields.
interface sqw_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [1:0] reg_index;
  logic [7:0] data;
  modport source (output valid, output op, output reg_index, output data, input ready);
  modport sink (input valid, input op, input reg_index, input data, output ready);
endinterface

interface sqw_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] sample;
  logic       length_active;
  logic       sweep_overflow;
  modport source (output valid, output sample, output length_active, output sweep_overflow,
                  input ready);
  modport sink (input valid, input sample, input length_active, input sweep_overflow,
                output ready);
endinterface

interface sqw_cfg_if;
  logic valid;
  logic ready;
  logic first_channel;
  modport source (output valid, output first_channel, input ready);
  modport sink (input valid, input first_channel, output ready);
endinterface

[rtl/square_wave_sound_channel.sv]
// Top level of the pulse sound channel: front end, command queue, back end.
// Depends on sqw_pkg, sqw_if, sqw_front, sqw_queue and sqw_back.
//
// Usage:
//   in_ch carries one event per word: op, reg_index and data. Ops cover the
//   four register writes, the enable write, length, envelope and sweep clocks
//   and the duty step. Every event gives exactly one result word on out_ch:
//   the held sample, the length status and the sweep carry after that event.
//   cfg_ch writes first_channel (reset 1); write it only while the block is
//   idle. cfg_ch.ready is always high.
//   A result word passes through the command queue and then the output
//   register before it shows on out_ch.
//   Throughput: one event per cycle while out_ch takes its words; the back end
//   updates the channel state once per command, which sets that rate.
//   Reset clears all channel state, the queue and the output valid flag.
//   When out_ch stalls, the output register holds its word and the queue of
//   QUEUE_DEPTH commands keeps taking events; in_ch.ready drops once it fills.
module square_wave_sound_channel import sqw_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sqw_in_if.sink    in_ch,
  sqw_cfg_if.sink   cfg_ch,
  sqw_out_if.source out_ch
);

  logic push_valid, push_ready;
  logic pop_valid, pop_ready;
  cmd_t push_data, pop_data;

  sqw_front u_front (
    .in_ch        (in_ch),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  sqw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  sqw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .cfg_ch      (cfg_ch),
    .out_ch      (out_ch)
  );

endmodule

[rtl/sqw_front.sv]
// Front end: accepts events and decodes op and register number into a command.
// Depends on sqw_pkg and sqw_in_if.
module sqw_front import sqw_pkg::*; (
  sqw_in_if.sink in_ch,
  output logic   push_valid_o,
  input  logic   push_ready_i,
  output cmd_t   push_data_o
);

  cmd_e cmd;

  always_comb begin
    cmd = CMD_NOP;
    case (op_e'(in_ch.op))
      OP_REG_WRITE: begin
        case (reg_e'(in_ch.reg_index))
          REG_ENVELOPE: cmd = CMD_WR_ENV;
          REG_SWEEP:    cmd = CMD_WR_SWEEP;
          REG_PER_LO:   cmd = CMD_WR_PER_LO;
          REG_PER_HI:   cmd = CMD_WR_PER_HI;
          default:      cmd = CMD_NOP;
        endcase
      end
      OP_ENABLE:    cmd = CMD_ENABLE;
      OP_LEN_CLOCK: cmd = CMD_LEN_CLK;
      OP_ENV_CLOCK: cmd = CMD_ENV_CLK;
      OP_SWP_CLOCK: cmd = CMD_SWP_CLK;
      OP_DUTY_STEP: cmd = CMD_DUTY_STEP;
      default:      cmd = CMD_NOP;
    endcase
  end

  assign push_valid_o      = in_ch.valid;
  assign in_ch.ready       = push_ready_i;
  assign push_data_o.cmd   = cmd;
  assign push_data_o.data  = in_ch.data;

endmodule

[rtl/sqw_queue.sv]
// Command queue between front and back end of the pulse sound channel.
// Depends on sqw_pkg for the command type.
module sqw_queue import sqw_pkg::*; #(
  parameter int DEPTH = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push_fire, pop_fire;

  assign push_ready_o = count_q != CntW'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push_fire    = push_valid_i && push_ready_o;
  assign pop_fire     = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_fire) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_fire, pop_fire})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/sqw_back.sv]
// Back end: executes commands on the channel state and registers the result.
// Depends on sqw_pkg, sqw_out_if and sqw_cfg_if.
module sqw_back import sqw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    pop_valid_i,
  output logic    pop_ready_o,
  input  cmd_t    pop_data_i,
  sqw_cfg_if.sink cfg_ch,
  sqw_out_if.source out_ch
);

  chan_t       st_q, st_d;
  logic        first_channel_q;
  logic        out_valid_q, out_valid_d;
  result_t     result_q;
  logic        pop_fire;
  logic        resample_en;
  logic [7:0]  data;
  logic [11:0] sweep_delta;
  logic [12:0] sweep_sum;

  assign data        = pop_data_i.data;
  assign pop_ready_o = !out_valid_q || out_ch.ready;
  assign pop_fire    = pop_valid_i && pop_ready_o;
  assign sweep_delta = st_q.timer_period >> st_q.sweep_shift;
  assign sweep_sum   = {1'b0, st_q.timer_period} + {1'b0, sweep_delta};
  assign out_valid_d = pop_fire || (out_valid_q && !out_ch.ready);
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    st_d        = st_q;
    resample_en = 1'b0;
    case (pop_data_i.cmd)
      CMD_WR_ENV: begin
        st_d.const_volume  = data[4];
        st_d.env_rate      = data[3:0];
        st_d.env_loop      = data[5];
        st_d.duty_select   = data[7:6];
        st_d.length_enable = !data[5];
        st_d.out_volume    = data[4] ? data[3:0] : st_q.env_level;
        resample_en        = 1'b1;
      end
      CMD_WR_SWEEP: begin
        st_d.sweep_on     = data[7];
        st_d.sweep_rate   = data[6:4];
        st_d.sweep_down   = data[3];
        st_d.sweep_shift  = data[2:0];
        st_d.sweep_reload = 1'b1;
      end
      CMD_WR_PER_LO: begin
        st_d.timer_period = {1'b0, st_q.timer_period[10:8], data};
      end
      CMD_WR_PER_HI: begin
        st_d.timer_period = {1'b0, data[2:0], st_q.timer_period[7:0]};
        if (st_q.channel_on) begin
          st_d.length_count = LengthTable[data[7:3]];
        end
        st_d.env_restart = 1'b1;
      end
      CMD_ENABLE: begin
        st_d.channel_on = data[0];
        if (!data[0]) begin
          st_d.length_count = '0;
        end
        resample_en = 1'b1;
      end
      CMD_LEN_CLK: begin
        if (st_q.length_enable && st_q.length_count != '0) begin
          st_d.length_count = st_q.length_count - 1'b1;
          resample_en       = st_q.length_count == 8'd1;
        end
      end
      CMD_ENV_CLK: begin
        if (st_q.env_restart) begin
          st_d.env_restart = 1'b0;
          st_d.env_divider = {1'b0, st_q.env_rate} + 5'd1;
          st_d.env_level   = LevelMax;
        end else if (st_q.env_divider <= 5'd1) begin
          st_d.env_divider = {1'b0, st_q.env_rate} + 5'd1;
          if (st_q.env_level != '0) begin
            st_d.env_level = st_q.env_level - 1'b1;
          end else begin
            st_d.env_level = st_q.env_loop ? LevelMax : '0;
          end
        end else begin
          st_d.env_divider = st_q.env_divider - 1'b1;
        end
        st_d.out_volume = st_q.const_volume ? st_q.env_rate : st_d.env_level;
        resample_en     = 1'b1;
      end
      CMD_SWP_CLK: begin
        if (st_q.sweep_divider <= 4'd1) begin
          st_d.sweep_divider = {1'b0, st_q.sweep_rate} + 4'd1;
          if (st_q.sweep_on && st_q.sweep_shift != '0 && st_q.timer_period > PeriodMin) begin
            st_d.carry_flag = 1'b0;
            if (!st_q.sweep_down) begin
              if (sweep_sum > {1'b0, PeriodLimit}) begin
                st_d.timer_period = PeriodLimit;
                st_d.carry_flag   = 1'b1;
              end else begin
                st_d.timer_period = sweep_sum[11:0];
              end
            end else begin
              st_d.timer_period = st_q.timer_period - sweep_delta
                                  - {11'd0, first_channel_q};
            end
          end
        end else begin
          st_d.sweep_divider = st_q.sweep_divider - 1'b1;
        end
        if (st_q.sweep_reload) begin
          st_d.sweep_reload  = 1'b0;
          st_d.sweep_divider = {1'b0, st_q.sweep_rate} + 4'd1;
        end
      end
      CMD_DUTY_STEP: begin
        st_d.duty_position = st_q.duty_position + 1'b1;
        resample_en        = 1'b1;
      end
      default: begin
        st_d = st_q;
      end
    endcase
    if (resample_en) begin
      st_d.held_sample = resample(st_d.channel_on, st_d.length_count, st_d.timer_period,
                                  st_d.sweep_down, st_d.sweep_shift, st_d.out_volume,
                                  st_d.duty_select, st_d.duty_position);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q            <= '0;
      first_channel_q <= 1'b1;
      out_valid_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_fire) begin
        st_q <= st_d;
      end
      if (cfg_ch.valid) begin
        first_channel_q <= cfg_ch.first_channel;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_fire) begin
      result_q.sample         <= st_d.held_sample;
      result_q.length_active  <= st_d.channel_on && st_d.length_count != '0;
      result_q.sweep_overflow <= st_d.carry_flag;
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.sample         = result_q.sample;
  assign out_ch.length_active  = result_q.length_active;
  assign out_ch.sweep_overflow = result_q.sweep_overflow;

endmodule

[rtl/sqw_checker.sv]
// Port-level checker of the pulse sound channel, bound to the top level.
// Depends on square_wave_sound_channel_macros.svh.
`include "square_wave_sound_channel_macros.svh"

module sqw_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [3:0] out_sample_i,
  input logic       out_length_active_i,
  input logic       out_sweep_overflow_i
);

  logic       in_fire;
  logic       out_stall;
  logic       out_inactive;
  logic [5:0] out_word;

  assign in_fire      = in_valid_i && in_ready_i;
  assign out_stall    = out_valid_i && !out_ready_i;
  assign out_inactive = out_valid_i && !out_length_active_i;
  assign out_word     = {out_sample_i, out_length_active_i, out_sweep_overflow_i};

  `SQW_ASSERT_NXT(a_out_valid_hold, clk_i, rst_ni, out_stall, out_valid_i)
  `SQW_ASSERT_NXT(a_out_word_hold, clk_i, rst_ni, out_stall, $stable(out_word))
  `SQW_ASSERT_IMP(a_result_has_event, clk_i, rst_ni, $rose(out_valid_i), $past(in_fire, 2))
  `SQW_ASSERT_IMP(a_mute_when_inactive, clk_i, rst_ni, out_inactive, out_sample_i == 4'd0)

endmodule

bind square_wave_sound_channel sqw_checker u_sqw_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_ch.valid),
  .in_ready_i           (in_ch.ready),
  .out_valid_i          (out_ch.valid),
  .out_ready_i          (out_ch.ready),
  .out_sample_i         (out_ch.sample),
  .out_length_active_i  (out_ch.length_active),
  .out_sweep_overflow_i (out_ch.sweep_overflow)
);
